[rtl/polyphonic_fm_synth_voice_engine_unit_defines.svh]
`ifndef POLYPHONIC_FM_SYNTH_VOICE_ENGINE_UNIT_DEFINES_SVH
`define POLYPHONIC_FM_SYNTH_VOICE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFMSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pfmse_pkg.sv]
package pfmse_pkg;

	localparam int VOICE_COUNT      = 64;
	localparam int AUDIO_FS_HZ      = 48000;
	localparam int PHASE_BITS       = 24;
	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int VIDX_W    = $clog2(VOICE_COUNT);
	localparam int VCNT_W    = $clog2(VOICE_COUNT + 1);
	localparam int SIN_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int TURN_PAD  = 32 - PHASE_BITS;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int SAMPLE_W  = 24;
	localparam int ELAPSED_W = 24;
	localparam int DIV_STEPS = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd3;

	localparam logic [19:0] ATTACK_RST  = 20'd4800;
	localparam logic [19:0] DECAY_RST   = 20'd9600;
	localparam logic [19:0] RELEASE_RST = 20'd96000;
	localparam logic [15:0] SUSTAIN_RST = 16'd39322;
	localparam logic [15:0] RATIO_RST   = 16'd16384;

	localparam logic [7:0] MIDI_NOTE_ON  = 8'd144;
	localparam logic [7:0] MIDI_NOTE_OFF = 8'd128;
	localparam logic [7:0] MIDI_KNOB     = 8'd176;

	typedef enum logic [1:0] {
		RES_SAMPLE  = 2'd0,
		RES_APPLIED = 2'd1,
		RES_DROPPED = 2'd2,
		RES_UNKNOWN = 2'd3
	} result_code_t;

	localparam logic [14:0] SIN_A        = 15'd25736;
	localparam logic [13:0] SIN_B        = 14'd10512;
	localparam logic [16:0] SIN_C        = 17'd1160;
	localparam logic [16:0] TURN_PER_RAD = 17'd20861;
	localparam logic [16:0] VOICE_GAIN   = 17'd39631;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 24'hFFFFFF;
	localparam logic signed [31:0] SAMPLE_MAX = 32'sd8388607;
	localparam logic signed [31:0] SAMPLE_MIN = -32'sd8388608;

	localparam logic [31:0] TOP_C_Q16 = 32'd548668578;
	localparam logic [63:0] RATE_DIV  = 64'(AUDIO_FS_HZ) << 16;

	localparam logic [31:0] SEMITONE_Q30 [12] = '{
		32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
		32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
		32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
	};

	typedef logic [PHASE_BITS-1:0] inc_table_t [128];
	typedef logic [15:0] ratio_table_t [128];

	function automatic inc_table_t build_pitch_table();
		inc_table_t  tbl;
		logic [63:0] f;
		int          oct;
		int          k;
		for (int n = 0; n < 128; n++) begin
			oct = n / 12;
			k = n % 12;
			f = (64'(TOP_C_Q16) * 64'(SEMITONE_Q30[k])) >> 30;
			f = f >> (10 - oct);
			tbl[n] = PHASE_BITS'((f << PHASE_BITS) / RATE_DIV);
		end
		return tbl;
	endfunction

	function automatic ratio_table_t build_knob_table();
		ratio_table_t tbl;
		for (int v = 0; v < 128; v++)
			tbl[v] = 16'(8192 + (v * 49152 + 63) / 127);
		return tbl;
	endfunction

	localparam inc_table_t   PITCH_INC  = build_pitch_table();
	localparam ratio_table_t KNOB_RATIO = build_knob_table();

	typedef struct packed {
		logic [6:0]            note;
		logic [6:0]            amp;
		logic [PHASE_BITS-1:0] cph;
		logic [PHASE_BITS-1:0] mph;
		logic [ELAPSED_W-1:0]  elapsed;
		logic [ELAPSED_W-1:0]  rel_start;
	} voice_rec_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ON_SCAN,
		S_OFF_SCAN,
		S_OFF_RD,
		S_T_SCAN,
		S_T_RD,
		S_MINC,
		S_SIN1,
		S_SIN2,
		S_SIN3,
		S_SIN4,
		S_MROT,
		S_ENV,
		S_DIV,
		S_MAG1,
		S_MAG2,
		S_MAG3,
		S_MAG4,
		S_WB,
		S_FIN
	} fsm_state_t;

endpackage

[rtl/polyphonic_fm_synth_voice_engine_unit.sv]
// Tick: scan all slots; each active voice runs the modulator, carrier, envelope
//   (with the divider when it runs) and magnitude steps, then is written back.
// Note-on finds a free slot; note-off scans, reading each unreleased voice.
// Knob and unknown messages need no scan. One item at a time; all voice math
//   runs through one shared 32x17 multiplier and one restoring divider.
// Reset: all voices free, registers at defaults, mod ratio 1.0, no result.
module polyphonic_fm_synth_voice_engine_unit import pfmse_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [7:0]                 midi_status,
	input  logic [6:0]                 midi_note,
	input  logic [6:0]                 midi_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] audio_sample,
	output logic [1:0]                 status,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	fsm_state_t state_q, state_d;

	logic [19:0] attack_q, decay_q, release_q;
	logic [15:0] sustain_q, ratio_q;
	logic [VOICE_COUNT-1:0] active_q, released_q;

	logic [VCNT_W-1:0] idx_q;
	logic [VIDX_W-1:0] vidx;
	logic [6:0] note_in_q, val_in_q;

	voice_rec_t rec_q, ram_rdata, ram_wdata;
	logic ram_we;

	logic [PHASE_BITS-1:0] inc_q, cph_q, mph_q, mph_n;
	logic [31:0] turn_q;
	logic [14:0] t_q, t2_q, mid_q;
	logic [13:0] inner_q;
	logic [1:0]  quad_q;
	logic signed [15:0] sin_q;
	logic [14:0] sin_abs;
	logic sel_car_q;

	logic [16:0] env_q;
	logic [16:0] env_base_q;
	logic [19:0] rem_q, div_q;
	logic [16:0] dvd_lo_q;
	logic [4:0]  cnt_q;
	logic [31:0] x_q;
	logic [22:0] y_q;
	logic [42:0] plo_q;
	logic [21:0] mag_q;
	logic signed [31:0] acc_q;

	logic signed [SAMPLE_W-1:0] res_sample_q, sample_q;
	result_code_t res_code_q;
	logic [1:0] code_q;
	logic out_valid_q;

	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] prod;

	// sine argument split
	logic [SIN_IDX_W-1:0] sidx;
	logic [1:0]  quad_c;
	logic [13:0] traw;
	logic [14:0] t_c;

	// envelope decision
	logic [ELAPSED_W-1:0] el, off, el_new;
	logic e_le_att, e_le_dec, off_le_rel, free_v;
	logic [19:0] dec_diff, rel_diff;
	logic env_go_div;
	logic [16:0] env_imm;
	logic [36:0] dvd_c;
	logic [19:0] dsr_c;

	logic [20:0] trial;
	logic div_ge;
	logic [15:0] s2;
	logic [14:0] smag;
	logic [31:0] rot;
	logic [53:0] mag_full;
	logic signed [31:0] term;
	logic fin_load;

	assign vidx = idx_q[VIDX_W-1:0];
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign audio_sample = sample_q;
	assign status = code_q;

	pfmse_ram #(.WIDTH($bits(voice_rec_t)), .DEPTH(VOICE_COUNT)) u_voice_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vidx),
		.wdata (ram_wdata),
		.raddr (vidx),
		.rdata (ram_rdata)
	);

	assign sidx   = turn_q[31 -: SIN_IDX_W];
	assign quad_c = sidx[SIN_IDX_W-1 -: 2];
	assign traw   = {sidx[SIN_IDX_W-3:0], {(16 - SIN_IDX_W){1'b0}}};
	assign t_c    = quad_c[0] ? (15'd16384 - {1'b0, traw}) : {1'b0, traw};

	assign sin_abs = sin_q[15] ? 15'(-sin_q) : sin_q[14:0];

	assign el         = rec_q.elapsed;
	assign e_le_att   = (el <= ELAPSED_W'(attack_q));
	assign e_le_dec   = (el <= ELAPSED_W'(decay_q));
	assign off        = el - rec_q.rel_start;
	assign off_le_rel = (off <= ELAPSED_W'(release_q));
	assign dec_diff   = decay_q - el[19:0];
	assign rel_diff   = release_q - off[19:0];
	assign el_new     = (el == ELAPSED_MAX) ? el : el + 1'b1;
	assign free_v     = released_q[vidx] &&
		((el_new - rec_q.rel_start) >= ELAPSED_W'(release_q));

	assign mph_n = rec_q.mph + prod[PHASE_BITS+13:14];

	assign trial  = {rem_q, dvd_lo_q[16]};
	assign div_ge = (trial >= {1'b0, div_q});

	assign s2   = {prod[28:14], 1'b0};
	assign smag = s2[15] ? 15'h7FFF : s2[14:0];
	assign rot  = sin_q[15] ? (32'd0 - prod[31:0]) : prod[31:0];

	assign mag_full = (54'(prod[42:0]) << 12) + 54'(plo_q);
	assign term = sin_q[15] ? -$signed({10'd0, mag_q}) : $signed({10'd0, mag_q});

	assign fin_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MINC: begin
				mul_a = 32'(inc_q);
				mul_b = 17'(ratio_q);
			end
			S_SIN1: begin
				mul_a = 32'(t_c);
				mul_b = 17'(t_c);
			end
			S_SIN2: begin
				mul_a = 32'(t2_q);
				mul_b = SIN_C;
			end
			S_SIN3: begin
				mul_a = 32'(t2_q);
				mul_b = 17'(inner_q);
			end
			S_SIN4: begin
				mul_a = 32'(t_q);
				mul_b = 17'(mid_q);
			end
			S_MROT: begin
				mul_a = 32'(sin_abs);
				mul_b = TURN_PER_RAD;
			end
			S_ENV: begin
				if (e_le_dec) begin
					mul_a = 32'(dec_diff);
					mul_b = 17'h10000 - 17'(sustain_q);
				end else begin
					mul_a = 32'(rel_diff);
					mul_b = 17'(sustain_q);
				end
			end
			S_MAG1: begin
				mul_a = 32'(sin_abs);
				mul_b = env_q;
			end
			S_MAG2: begin
				mul_a = 32'(rec_q.amp);
				mul_b = VOICE_GAIN;
			end
			S_MAG3: begin
				mul_a = x_q;
				mul_b = 17'(y_q[11:0]);
			end
			S_MAG4: begin
				mul_a = x_q;
				mul_b = 17'(y_q[22:12]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 49'(mul_a) * 49'(mul_b);

	// envelope branch: immediate value (sustain or zero) or a division
	always_comb begin
		env_go_div = 1'b0;
		env_imm = '0;
		dvd_c = '0;
		dsr_c = attack_q;
		if (e_le_att) begin
			if (attack_q != '0) begin
				env_go_div = 1'b1;
				dvd_c = {1'b0, el[19:0], 16'd0};
			end
		end else if (e_le_dec) begin
			env_go_div = 1'b1;
			dvd_c = prod[36:0];
			dsr_c = decay_q;
		end else if (!released_q[vidx]) begin
			env_imm = 17'(sustain_q);
		end else if (off_le_rel && release_q != '0) begin
			env_go_div = 1'b1;
			dvd_c = prod[36:0];
			dsr_c = release_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!req_type) begin
						state_d = S_T_SCAN;
					end else begin
						case (midi_status)
							MIDI_NOTE_ON:  state_d = S_ON_SCAN;
							MIDI_NOTE_OFF: state_d = S_OFF_SCAN;
							default:       state_d = S_FIN;
						endcase
					end
				end
			end
			S_ON_SCAN: begin
				if (idx_q == VCNT_W'(VOICE_COUNT)) begin
					state_d = S_FIN;
				end else if (!active_q[vidx]) begin
					ram_we = 1'b1;
					ram_wdata = '{note: note_in_q, amp: val_in_q, cph: '0, mph: '0,
						elapsed: '0, rel_start: '0};
					state_d = S_FIN;
				end
			end
			S_OFF_SCAN: begin
				if (idx_q == VCNT_W'(VOICE_COUNT))
					state_d = S_FIN;
				else if (active_q[vidx] && !released_q[vidx])
					state_d = S_OFF_RD;
			end
			S_OFF_RD: begin
				if (ram_rdata.note == note_in_q) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata;
					ram_wdata.rel_start = ram_rdata.elapsed;
				end
				state_d = S_OFF_SCAN;
			end
			S_T_SCAN: begin
				if (idx_q == VCNT_W'(VOICE_COUNT))
					state_d = S_FIN;
				else if (active_q[vidx])
					state_d = S_T_RD;
			end
			S_T_RD: state_d = S_MINC;
			S_MINC: state_d = S_SIN1;
			S_SIN1: state_d = S_SIN2;
			S_SIN2: state_d = S_SIN3;
			S_SIN3: state_d = S_SIN4;
			S_SIN4: state_d = sel_car_q ? S_ENV : S_MROT;
			S_MROT: state_d = S_SIN1;
			S_ENV:  state_d = env_go_div ? S_DIV : S_MAG1;
			S_DIV: begin
				if (cnt_q == 5'(DIV_STEPS - 1))
					state_d = S_MAG1;
			end
			S_MAG1: state_d = S_MAG2;
			S_MAG2: state_d = S_MAG3;
			S_MAG3: state_d = S_MAG4;
			S_MAG4: state_d = S_WB;
			S_WB: begin
				ram_we = 1'b1;
				ram_wdata = rec_q;
				ram_wdata.cph = cph_q;
				ram_wdata.mph = mph_q;
				ram_wdata.elapsed = el_new;
				state_d = S_T_SCAN;
			end
			S_FIN: begin
				if (fin_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			decay_q <= DECAY_RST;
			release_q <= RELEASE_RST;
			sustain_q <= SUSTAIN_RST;
			ratio_q <= RATIO_RST;
			active_q <= '0;
			released_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			sel_car_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK:  attack_q <= cfg_data;
					REG_DECAY:   decay_q <= cfg_data;
					REG_RELEASE: release_q <= cfg_data;
					REG_SUSTAIN: sustain_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_valid && req_type && midi_status == MIDI_KNOB)
						ratio_q <= KNOB_RATIO[midi_value];
				end
				S_ON_SCAN: begin
					if (idx_q != VCNT_W'(VOICE_COUNT)) begin
						if (!active_q[vidx]) begin
							active_q[vidx] <= 1'b1;
							released_q[vidx] <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_OFF_SCAN, S_T_SCAN: begin
					if (idx_q != VCNT_W'(VOICE_COUNT) && !(active_q[vidx] &&
						(state_q == S_T_SCAN || !released_q[vidx])))
						idx_q <= idx_q + 1'b1;
				end
				S_OFF_RD: begin
					if (ram_rdata.note == note_in_q)
						released_q[vidx] <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				S_MINC: sel_car_q <= 1'b0;
				S_MROT: sel_car_q <= 1'b1;
				S_ENV:  cnt_q <= '0;
				S_DIV:  cnt_q <= cnt_q + 1'b1;
				S_WB: begin
					if (free_v)
						active_q[vidx] <= 1'b0;
					idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (fin_load) begin
			sample_q <= res_sample_q;
			code_q <= res_code_q;
		end
		case (state_q)
			S_IDLE: begin
				note_in_q <= midi_note;
				val_in_q <= midi_value;
				acc_q <= '0;
				res_sample_q <= '0;
				if (!req_type)
					res_code_q <= RES_SAMPLE;
				else if (midi_status == MIDI_KNOB)
					res_code_q <= RES_APPLIED;
				else
					res_code_q <= RES_UNKNOWN;
			end
			S_ON_SCAN: begin
				if (idx_q == VCNT_W'(VOICE_COUNT))
					res_code_q <= RES_DROPPED;
				else
					res_code_q <= RES_APPLIED;
			end
			S_OFF_SCAN: res_code_q <= RES_APPLIED;
			S_T_SCAN: begin
				if (acc_q > SAMPLE_MAX)
					res_sample_q <= SAMPLE_W'(SAMPLE_MAX);
				else if (acc_q < SAMPLE_MIN)
					res_sample_q <= SAMPLE_W'(SAMPLE_MIN);
				else
					res_sample_q <= acc_q[SAMPLE_W-1:0];
			end
			S_T_RD: begin
				rec_q <= ram_rdata;
				inc_q <= PITCH_INC[ram_rdata.note];
			end
			S_MINC: begin
				mph_q <= mph_n;
				cph_q <= rec_q.cph + inc_q;
				turn_q <= {mph_n, {TURN_PAD{1'b0}}};
			end
			S_SIN1: begin
				t_q <= t_c;
				quad_q <= quad_c;
				t2_q <= prod[28:14];
			end
			S_SIN2: inner_q <= SIN_B - prod[27:14];
			S_SIN3: mid_q <= SIN_A - {1'b0, prod[27:14]};
			S_SIN4: sin_q <= quad_q[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
			S_MROT: turn_q <= {cph_q, {TURN_PAD{1'b0}}} + rot;
			S_ENV: begin
				env_q <= env_imm;
				// decay segment sits on top of the sustain level
				env_base_q <= (!e_le_att && e_le_dec) ? 17'(sustain_q) : '0;
				rem_q <= dvd_c[36:17];
				dvd_lo_q <= dvd_c[16:0];
				div_q <= dsr_c;
			end
			S_DIV: begin
				rem_q <= div_ge ? 20'(trial - {1'b0, div_q}) : trial[19:0];
				dvd_lo_q <= {dvd_lo_q[15:0], div_ge};
				env_q <= {dvd_lo_q[15:0], div_ge} + env_base_q;
			end
			S_MAG1: x_q <= prod[31:0];
			S_MAG2: y_q <= prod[22:0];
			S_MAG3: plo_q <= prod[42:0];
			S_MAG4: mag_q <= mag_full[53:32];
			S_WB:   acc_q <= acc_q + term;
			default: ;
		endcase
	end

endmodule

[rtl/pfmse_ram.sv]
module pfmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/pfmse_chk.sv]
`include "polyphonic_fm_synth_voice_engine_unit_defines.svh"

module pfmse_chk import pfmse_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] audio_sample,
	input logic [1:0]                 status
);

	`PFMSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	`PFMSE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(audio_sample) && $stable(status), "result changed under stall")
	`PFMSE_ASSERT_NOW(a_midi_silent, out_valid && status != RES_SAMPLE, audio_sample == '0, "MIDI result carries audio")
	`PFMSE_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind polyphonic_fm_synth_voice_engine_unit pfmse_chk u_pfmse_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.audio_sample (audio_sample),
	.status       (status)
);
